### rtl/ila_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ila_pkg
// Shared types, codes and helper functions of the indicator light arbiter.
// ----------------------------------------------------------------------------
package ila_pkg;

  localparam logic [2:0] CMD_BACKLIGHT = 3'd0;
  localparam logic [2:0] CMD_BUTTONS   = 3'd1;
  localparam logic [2:0] CMD_ATTENTION = 3'd2;
  localparam logic [2:0] CMD_NOTIFY    = 3'd3;
  localparam logic [2:0] CMD_BATTERY   = 3'd4;

  localparam logic [2:0] TGT_BACKLIGHT = 3'd0;
  localparam logic [2:0] TGT_BUTTONS   = 3'd1;
  localparam logic [2:0] TGT_BLINK     = 3'd2;
  localparam logic [2:0] TGT_TIMES     = 3'd3;
  localparam logic [2:0] TGT_BRIGHT    = 3'd4;
  localparam logic [2:0] TGT_FLASH     = 3'd5;

  localparam logic [1:0] MODE_NONE = 2'd0;

  localparam logic [23:0] RGB_MASK = 24'hFFFFFF;
  localparam logic [7:0]  ALPHA_FULL = 8'hFF;

  typedef struct packed {
    logic [2:0]  target;
    logic [11:0] val_a;
    logic [7:0]  val_b;
    logic [7:0]  val_c;
    logic [7:0]  val_d;
  } wr_t;

  typedef struct packed {
    logic       load;
    logic       sel;
    logic       mix;
    logic       prod;
    logic       build;
    logic [1:0] idx;
  } ila_cmd_t;

  typedef struct packed {
    logic [1:0] build_cnt;
    logic       final_wr;
  } ila_stat_t;

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [7:0] time_code(input logic [15:0] ms);
    logic [7:0] c;
    if (ms <= 16'd1)          c = 8'd255;
    else if (ms <= 16'd250)   c = 8'd0;
    else if (ms <= 16'd500)   c = 8'd1;
    else if (ms <= 16'd1000)  c = 8'd2;
    else if (ms <= 16'd2500)  c = 8'd3;
    else if (ms <= 16'd5000)  c = 8'd4;
    else if (ms <= 16'd8000)  c = 8'd5;
    else if (ms <= 16'd15000) c = 8'd6;
    else                      c = 8'd7;
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/ila_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ila_ctrl
// Sequencer: accept, select, mix, multiply, build the write list, emit writes.
// ----------------------------------------------------------------------------
module ila_ctrl
  import ila_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire ila_stat_t stat,
  output ila_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SEL   = 6'b000010,
    S_MIX   = 6'b000100,
    S_PROD  = 6'b001000,
    S_BUILD = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SEL;
      S_SEL:   state_nxt = S_MIX;
      S_MIX:   state_nxt = S_PROD;
      S_PROD:  state_nxt = S_BUILD;
      S_BUILD: begin
        idx_nxt   = 2'd0;
        state_nxt = (stat.build_cnt == 2'd0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (stat.final_wr) state_nxt = S_IDLE;
          else idx_nxt = idx_r + 2'd1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  always_comb begin
    cmd       = '0;
    cmd.load  = in_valid && (state_r == S_IDLE);
    cmd.sel   = (state_r == S_SEL);
    cmd.mix   = (state_r == S_MIX);
    cmd.prod  = (state_r == S_PROD);
    cmd.build = (state_r == S_BUILD);
    cmd.idx   = idx_r;
  end

endmodule
`default_nettype wire

### rtl/ila_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ila_dp
// Source state, indicator selection, brightness arithmetic and write list.
// ----------------------------------------------------------------------------
module ila_dp
  import ila_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ila_cmd_t    cmd,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [31:0] in_color,
  input  wire logic [1:0]  in_flash_mode,
  input  wire logic [15:0] in_flash_on_ms,
  input  wire logic [15:0] in_flash_off_ms,
  input  wire logic        in_multi_led,
  input  wire logic [7:0]  in_flashlight_level,
  output ila_stat_t        stat,
  output logic [2:0]       out_target,
  output logic [11:0]      out_value_a,
  output logic [7:0]       out_value_b,
  output logic [7:0]       out_value_c,
  output logic [7:0]       out_value_d,
  output logic             out_last
);

  logic [2:0]  req_cmd_r;
  logic [31:0] req_color_r;
  logic        req_multi_r;
  logic [7:0]  req_level_r;

  logic [31:0] att_color_r, ntf_color_r, bat_color_r, shw_color_r;
  logic [1:0]  att_mode_r, ntf_mode_r, bat_mode_r, shw_mode_r;
  logic [15:0] att_on_r, ntf_on_r, bat_on_r, shw_on_r;
  logic [15:0] att_off_r, ntf_off_r, bat_off_r, shw_off_r;
  logic        att_multi_r;
  logic [11:0] bl_last_r;
  logic        bl_known_r;
  logic [7:0]  btn_last_r;
  logic        btn_known_r;
  logic [7:0]  fl_last_r;
  logic        fl_known_r;
  logic        fl_in_use_r;

  logic [31:0] work_color_r;
  logic [1:0]  sel_mode_r;
  logic [15:0] sel_on_r, sel_off_r;
  logic        ind_chg_r;
  logic [7:0]  wsum_r, maxv_r, alpha_r;
  logic [15:0] luma_p_r, maxc_p_r;
  wr_t         q_r [3];
  logic [1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r   <= in_cmd;
      req_color_r <= in_color;
      req_multi_r <= in_multi_led;
      req_level_r <= in_flashlight_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_color_r <= '0; att_mode_r <= '0; att_on_r <= '0; att_off_r <= '0;
      att_multi_r <= 1'b0;
      ntf_color_r <= '0; ntf_mode_r <= '0; ntf_on_r <= '0; ntf_off_r <= '0;
      bat_color_r <= '0; bat_mode_r <= '0; bat_on_r <= '0; bat_off_r <= '0;
    end else if (cmd.load) begin
      case (in_cmd)
        CMD_ATTENTION: begin
          att_color_r <= in_color;        att_mode_r <= in_flash_mode;
          att_on_r    <= in_flash_on_ms;  att_off_r  <= in_flash_off_ms;
          att_multi_r <= in_multi_led;
        end
        CMD_NOTIFY: begin
          ntf_color_r <= in_color;        ntf_mode_r <= in_flash_mode;
          ntf_on_r    <= in_flash_on_ms;  ntf_off_r  <= in_flash_off_ms;
        end
        CMD_BATTERY: begin
          bat_color_r <= in_color;        bat_mode_r <= in_flash_mode;
          bat_on_r    <= in_flash_on_ms;  bat_off_r  <= in_flash_off_ms;
        end
        default: ;
      endcase
    end
  end

  logic [31:0] ch_color;
  logic [1:0]  ch_mode;
  logic [15:0] ch_on, ch_off;
  logic        ind_req, ch_diff;

  always_comb begin
    if (!att_multi_r && ((att_color_r[23:0] & RGB_MASK) != 24'd0)) begin
      ch_color = att_color_r; ch_mode = att_mode_r; ch_on = att_on_r; ch_off = att_off_r;
    end else if ((ntf_color_r[23:0] & RGB_MASK) != 24'd0) begin
      ch_color = ntf_color_r; ch_mode = ntf_mode_r; ch_on = ntf_on_r; ch_off = ntf_off_r;
    end else begin
      ch_color = bat_color_r; ch_mode = bat_mode_r; ch_on = bat_on_r; ch_off = bat_off_r;
    end
    ind_req = (req_cmd_r inside {CMD_NOTIFY, CMD_BATTERY}) ||
              ((req_cmd_r == CMD_ATTENTION) && !req_multi_r);
    ch_diff = (ch_color != shw_color_r) || (ch_mode != shw_mode_r) ||
              (ch_on != shw_on_r) || (ch_off != shw_off_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      work_color_r <= ind_req ? ch_color : req_color_r;
      sel_mode_r   <= ch_mode;
      sel_on_r     <= ch_on;
      sel_off_r    <= ch_off;
      ind_chg_r    <= ch_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shw_color_r <= '0; shw_mode_r <= '0; shw_on_r <= '0; shw_off_r <= '0;
    end else if (cmd.sel && ind_req && ch_diff) begin
      shw_color_r <= ch_color; shw_mode_r <= ch_mode;
      shw_on_r    <= ch_on;    shw_off_r  <= ch_off;
    end
  end

  logic [7:0]  cr, cg, cb, ca, mrg;
  logic [15:0] wsum;

  always_comb begin
    cr   = work_color_r[23:16];
    cg   = work_color_r[15:8];
    cb   = work_color_r[7:0];
    ca   = work_color_r[31:24];
    wsum = 16'd77 * {8'd0, cr} + 16'd150 * {8'd0, cg} + 16'd29 * {8'd0, cb};
    mrg  = (cr > cg) ? cr : cg;
    if (cb > mrg) mrg = cb;
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      wsum_r  <= wsum[15:8];
      maxv_r  <= mrg;
      alpha_r <= (ca == 8'd0) ? ALPHA_FULL : ca;
    end
    if (cmd.prod) begin
      luma_p_r <= {8'd0, wsum_r} * {8'd0, alpha_r};
      maxc_p_r <= {8'd0, maxv_r} * {8'd0, alpha_r};
    end
  end

  logic [7:0]  luma, maxc, tc_on, tc_off;
  logic [11:0] bl;
  wr_t         q_nxt [3];
  logic [1:0]  cnt_nxt;
  logic        bl_upd, btn_upd, fl_upd, fl_wr;

  always_comb begin
    luma    = div255(luma_p_r);
    maxc    = div255(maxc_p_r);
    tc_on   = time_code(sel_on_r);
    tc_off  = time_code(sel_off_r);
    bl      = (maxc == 8'd0) ? 12'd0 : {maxc, 4'hF};
    q_nxt[0] = '0;
    q_nxt[1] = '0;
    q_nxt[2] = '0;
    cnt_nxt = 2'd0;
    bl_upd  = 1'b0;
    btn_upd = 1'b0;
    fl_upd  = 1'b0;
    fl_wr   = 1'b0;
    case (req_cmd_r)
      CMD_BACKLIGHT: begin
        if (!bl_known_r || (bl_last_r != bl)) begin
          bl_upd = 1'b1;
          q_nxt[0].target = TGT_BACKLIGHT;
          q_nxt[0].val_a  = bl;
          cnt_nxt = 2'd1;
        end
      end
      CMD_BUTTONS: begin
        if (!btn_known_r || (btn_last_r != luma)) begin
          btn_upd = 1'b1;
          q_nxt[0].target = TGT_BUTTONS;
          q_nxt[0].val_a  = {4'd0, luma};
          cnt_nxt = 2'd1;
        end
      end
      CMD_ATTENTION, CMD_NOTIFY, CMD_BATTERY: begin
        if ((req_cmd_r == CMD_ATTENTION) && req_multi_r) begin
          if (!fl_known_r || (fl_last_r != luma)) begin
            fl_upd = 1'b1;
            if (fl_in_use_r || (req_level_r == 8'd0)) begin
              fl_wr = 1'b1;
              q_nxt[0].target = TGT_FLASH;
              q_nxt[0].val_a  = {4'd0, luma};
              cnt_nxt = 2'd1;
            end
          end
        end else if (ind_chg_r) begin
          if (work_color_r[23:0] != 24'd0) begin
            if (sel_mode_r == MODE_NONE) begin
              q_nxt[0].target = TGT_BLINK;
              q_nxt[1].target = TGT_BRIGHT;
              q_nxt[1].val_a  = {4'd0, luma};
              cnt_nxt = 2'd2;
            end else begin
              q_nxt[0].target = TGT_TIMES;
              q_nxt[0].val_a  = {4'd0, tc_on};
              q_nxt[0].val_b  = tc_on >> 1;
              q_nxt[0].val_c  = tc_off;
              q_nxt[0].val_d  = tc_off >> 1;
              q_nxt[1].target = TGT_BLINK;
              q_nxt[1].val_a  = 12'd1;
              q_nxt[2].target = TGT_BRIGHT;
              q_nxt[2].val_a  = {4'd0, luma};
              cnt_nxt = 2'd3;
            end
          end else begin
            q_nxt[0].target = TGT_BRIGHT;
            q_nxt[1].target = TGT_BLINK;
            cnt_nxt = 2'd2;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.build) begin
      q_r[0] <= q_nxt[0];
      q_r[1] <= q_nxt[1];
      q_r[2] <= q_nxt[2];
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_last_r   <= '0; bl_known_r  <= 1'b0;
      btn_last_r  <= '0; btn_known_r <= 1'b0;
      fl_last_r   <= '0; fl_known_r  <= 1'b0;
      fl_in_use_r <= 1'b0;
    end else if (cmd.build) begin
      if (bl_upd) begin
        bl_last_r <= bl; bl_known_r <= 1'b1;
      end
      if (btn_upd) begin
        btn_last_r <= luma; btn_known_r <= 1'b1;
      end
      if (fl_upd) begin
        fl_last_r <= luma; fl_known_r <= 1'b1;
      end
      if (fl_wr) fl_in_use_r <= (luma != 8'd0);
    end
  end

  wr_t cur;

  always_comb begin
    cur = (cmd.idx == 2'd3) ? q_r[0] : q_r[cmd.idx];
    out_target  = cur.target;
    out_value_a = cur.val_a;
    out_value_b = cur.val_b;
    out_value_c = cur.val_c;
    out_value_d = cur.val_d;
    out_last    = (cmd.idx == (cnt_r - 2'd1));
    stat.build_cnt = cnt_nxt;
    stat.final_wr  = out_last;
  end

endmodule
`default_nettype wire

### rtl/indicator_light_arbiter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indicator_light_arbiter_unit
// Flow: a request is accepted, then selected and worked on in order
// (select, mix, multiply, build); writes follow, up to three, one per cycle
// while out_stall is low. The sequencer stalls new requests until it is idle.
// Reset: synchronous, active low; clears all source, shown and last-value state.
// ----------------------------------------------------------------------------
module indicator_light_arbiter_unit
  import ila_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [31:0] in_color,
  input  wire logic [1:0]  in_flash_mode,
  input  wire logic [15:0] in_flash_on_ms,
  input  wire logic [15:0] in_flash_off_ms,
  input  wire logic        in_multi_led,
  input  wire logic [7:0]  in_flashlight_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_target,
  output logic [11:0]      out_value_a,
  output logic [7:0]       out_value_b,
  output logic [7:0]       out_value_c,
  output logic [7:0]       out_value_d,
  output logic             out_last
);

  ila_cmd_t  cmd;
  ila_stat_t stat;

  ila_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ila_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_cmd              (in_cmd),
    .in_color            (in_color),
    .in_flash_mode       (in_flash_mode),
    .in_flash_on_ms      (in_flash_on_ms),
    .in_flash_off_ms     (in_flash_off_ms),
    .in_multi_led        (in_multi_led),
    .in_flashlight_level (in_flashlight_level),
    .stat                (stat),
    .out_target          (out_target),
    .out_value_a         (out_value_a),
    .out_value_b         (out_value_b),
    .out_value_c         (out_value_c),
    .out_value_d         (out_value_d),
    .out_last            (out_last)
  );

endmodule
`default_nettype wire

### test/ila_write_monitor.sv
// ----------------------------------------------------------------------------
// ila_write_monitor
// Watches the request and write channels of the indicator light arbiter,
// keeps its own copy of the source, shown and last-value state, predicts the
// LED writes of every accepted request and compares each accepted write with
// the oldest prediction.
// ----------------------------------------------------------------------------
module ila_write_monitor
  import ila_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_color,
  input  logic [1:0]  in_flash_mode,
  input  logic [15:0] in_flash_on_ms,
  input  logic [15:0] in_flash_off_ms,
  input  logic        in_multi_led,
  input  logic [7:0]  in_flashlight_level,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_target,
  input  logic [11:0] out_value_a,
  input  logic [7:0]  out_value_b,
  input  logic [7:0]  out_value_c,
  input  logic [7:0]  out_value_d,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_writes
);

  typedef struct packed {
    logic [31:0] color;
    logic [1:0]  mode;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } light_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [11:0] value_a;
    logic [7:0]  value_b;
    logic [7:0]  value_c;
    logic [7:0]  value_d;
    logic        last;
  } led_write_t;

  light_t      attention, notify, battery, shown;
  logic        attention_multi;
  logic [11:0] backlight_last;
  logic        backlight_known;
  logic [7:0]  buttons_last;
  logic        buttons_known;
  logic [7:0]  flash_last;
  logic        flash_known;
  logic        flash_in_use;

  led_write_t  expected_writes[$];

  function automatic int unsigned alpha_scale(input logic [31:0] c);
    if (c[31:24] == 8'd0) begin
      return ALPHA_FULL;
    end
    return c[31:24];
  endfunction

  function automatic logic [7:0] luma_level(input logic [31:0] c);
    int unsigned mix;
    mix = (77 * int'(c[23:16]) + 150 * int'(c[15:8]) + 29 * int'(c[7:0])) >> 8;
    return 8'((mix * alpha_scale(c)) / 255);
  endfunction

  function automatic logic [7:0] peak_level(input logic [31:0] c);
    int unsigned peak;
    peak = c[23:16];
    if (c[15:8] > peak) peak = c[15:8];
    if (c[7:0] > peak) peak = c[7:0];
    return 8'((peak * alpha_scale(c)) / 255);
  endfunction

  function automatic logic [7:0] blink_code(input logic [15:0] ms);
    if (ms <= 16'd1) return 8'd255;
    if (ms <= 16'd250) return 8'd0;
    if (ms <= 16'd500) return 8'd1;
    if (ms <= 16'd1000) return 8'd2;
    if (ms <= 16'd2500) return 8'd3;
    if (ms <= 16'd5000) return 8'd4;
    if (ms <= 16'd8000) return 8'd5;
    if (ms <= 16'd15000) return 8'd6;
    return 8'd7;
  endfunction

  task automatic queue_write(input logic [2:0] target, input logic [11:0] a,
                             input logic [7:0] b, input logic [7:0] c,
                             input logic [7:0] d);
    led_write_t w;
    w.target  = target;
    w.value_a = a;
    w.value_b = b;
    w.value_c = c;
    w.value_d = d;
    w.last    = 1'b0;
    expected_writes.push_back(w);
  endtask

  task automatic refresh_indicator();
    light_t     pick;
    logic [7:0] on_code, off_code;
    if (!attention_multi && attention.color[23:0] != 24'd0) begin
      pick = attention;
    end else if (notify.color[23:0] != 24'd0) begin
      pick = notify;
    end else begin
      pick = battery;
    end
    if (pick == shown) return;
    shown = pick;
    if (pick.color[23:0] != 24'd0) begin
      if (pick.mode == MODE_NONE) begin
        queue_write(TGT_BLINK, 12'd0, 8'd0, 8'd0, 8'd0);
      end else begin
        on_code  = blink_code(pick.on_ms);
        off_code = blink_code(pick.off_ms);
        queue_write(TGT_TIMES, {4'd0, on_code}, on_code >> 1, off_code, off_code >> 1);
        queue_write(TGT_BLINK, 12'd1, 8'd0, 8'd0, 8'd0);
      end
      queue_write(TGT_BRIGHT, {4'd0, luma_level(pick.color)}, 8'd0, 8'd0, 8'd0);
    end else begin
      queue_write(TGT_BRIGHT, 12'd0, 8'd0, 8'd0, 8'd0);
      queue_write(TGT_BLINK, 12'd0, 8'd0, 8'd0, 8'd0);
    end
  endtask

  task automatic predict_request(input logic [2:0] cmd, input light_t req,
                                 input logic multi, input logic [7:0] level);
    int          prior_size;
    int unsigned scaled;
    logic [7:0]  bright;
    led_write_t  tail;
    prior_size = expected_writes.size();
    case (cmd)
      CMD_BACKLIGHT: begin
        scaled = peak_level(req.color);
        if (scaled != 0) scaled = (scaled + 1) * 16 - 1;
        if (!backlight_known || backlight_last != 12'(scaled)) begin
          queue_write(TGT_BACKLIGHT, 12'(scaled), 8'd0, 8'd0, 8'd0);
          backlight_last  = 12'(scaled);
          backlight_known = 1'b1;
        end
      end
      CMD_BUTTONS: begin
        bright = luma_level(req.color);
        if (!buttons_known || buttons_last != bright) begin
          queue_write(TGT_BUTTONS, {4'd0, bright}, 8'd0, 8'd0, 8'd0);
          buttons_last  = bright;
          buttons_known = 1'b1;
        end
      end
      CMD_ATTENTION: begin
        attention       = req;
        attention_multi = multi;
        if (!multi) begin
          refresh_indicator();
        end else begin
          bright = luma_level(req.color);
          if (!flash_known || flash_last != bright) begin
            if (flash_in_use || level == 8'd0) begin
              queue_write(TGT_FLASH, {4'd0, bright}, 8'd0, 8'd0, 8'd0);
              flash_in_use = (bright != 8'd0);
            end
            flash_last  = bright;
            flash_known = 1'b1;
          end
        end
      end
      CMD_NOTIFY: begin
        notify = req;
        refresh_indicator();
      end
      CMD_BATTERY: begin
        battery = req;
        refresh_indicator();
      end
      default: begin
      end
    endcase
    // mark the final write of this transaction
    if (expected_writes.size() > prior_size) begin
      tail = expected_writes.pop_back();
      tail.last = 1'b1;
      expected_writes.push_back(tail);
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    light_t     req;
    led_write_t want;
    if (!rst_n) begin
      attention       = '0;
      notify          = '0;
      battery         = '0;
      shown           = '0;
      attention_multi = 1'b0;
      backlight_last  = '0;
      backlight_known = 1'b0;
      buttons_last    = '0;
      buttons_known   = 1'b0;
      flash_last      = '0;
      flash_known     = 1'b0;
      flash_in_use    = 1'b0;
      expected_writes.delete();
    end else begin
      if (in_valid && !in_stall) begin
        req.color  = in_color;
        req.mode   = in_flash_mode;
        req.on_ms  = in_flash_on_ms;
        req.off_ms = in_flash_off_ms;
        predict_request(in_cmd, req, in_multi_led, in_flashlight_level);
      end
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $error("write with no transaction outstanding: target %0d value_a %0d",
                 out_target, out_value_a);
          fail_count++;
        end else begin
          want = expected_writes.pop_front();
          check_field("target", want.target, out_target);
          check_field("value_a", want.value_a, out_value_a);
          check_field("value_b", want.value_b, out_value_b);
          check_field("value_c", want.value_c, out_value_c);
          check_field("value_d", want.value_d, out_value_d);
          check_field("last", want.last, out_last);
        end
      end
    end
    pending_writes <= expected_writes.size();
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives light requests into the indicator light arbiter: a directed opening
// over the edge cases, then random transactions under changing sender and
// receiver idling, with one long receiver hold-off. The write monitor checks
// every LED write; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ila_pkg::*;

  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_TAIL  = 40;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] color;
    logic [1:0]  mode;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic        multi;
    logic [7:0]  level;
  } light_req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_cmd;
  logic [31:0] in_color;
  logic [1:0]  in_flash_mode;
  logic [15:0] in_flash_on_ms;
  logic [15:0] in_flash_off_ms;
  logic        in_multi_led;
  logic [7:0]  in_flashlight_level;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_target;
  logic [11:0] out_value_a;
  logic [7:0]  out_value_b;
  logic [7:0]  out_value_c;
  logic [7:0]  out_value_d;
  logic        out_last;
  int          fail_count;
  int          pending_writes;

  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_pending;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;
  light_req_t  recent_req [8];

  indicator_light_arbiter_unit dut (.*);

  ila_write_monitor monitor (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count == CYCLE_LIMIT);
    $display("indicator_light_arbiter_unit test failed");
    $finish;
  end

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (int n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_request(input light_req_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_cmd              <= req.cmd;
    in_color            <= req.color;
    in_flash_mode       <= req.mode;
    in_flash_on_ms      <= req.on_ms;
    in_flash_off_ms     <= req.off_ms;
    in_multi_led        <= req.multi;
    in_flashlight_level <= req.level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_fields(input logic [2:0] cmd, input logic [31:0] color,
                             input logic [1:0] mode, input logic [15:0] on_ms,
                             input logic [15:0] off_ms, input logic multi,
                             input logic [7:0] level);
    light_req_t req;
    req = '{cmd, color, mode, on_ms, off_ms, multi, level};
    send_request(req);
  endtask

  function automatic logic [15:0] pick_ms();
    logic [15:0] step_ms;
    case ($urandom_range(7))
      0:       step_ms = 16'd250;
      1:       step_ms = 16'd500;
      2:       step_ms = 16'd1000;
      3:       step_ms = 16'd2500;
      4:       step_ms = 16'd5000;
      5:       step_ms = 16'd8000;
      6:       step_ms = 16'd15000;
      default: step_ms = 16'd1;
    endcase
    case ($urandom_range(3))
      0:       return 16'(step_ms + $urandom_range(2) - 1);
      1:       return 16'($urandom_range(3));
      2:       return 16'($urandom);
      default: return 16'($urandom_range(20000));
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4:          return {8'h00, 24'($urandom)};
      5:          return {8'($urandom), 24'h0};
      6:          return 32'hFFFF_FFFF;
      7:          return {8'($urandom), 8'($urandom), 16'h0};
      8:          return 32'h0;
      default:    return {8'hFF, 16'h0, 8'($urandom)};
    endcase
  endfunction

  function automatic light_req_t random_request();
    light_req_t r;
    logic [2:0] cmd;
    if ($urandom_range(9) == 0) cmd = 3'($urandom_range(7, 5));
    else cmd = 3'($urandom_range(4));
    if ($urandom_range(4) == 0) begin
      // repeat the source's previous transaction to exercise the no-change paths
      r = recent_req[cmd];
    end else begin
      r.color  = pick_color();
      r.mode   = 2'($urandom_range(3));
      r.on_ms  = pick_ms();
      r.off_ms = pick_ms();
      r.multi  = ($urandom_range(2) == 0);
    end
    r.level = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom);
    r.cmd   = cmd;
    return r;
  endfunction

  task automatic run_random(input int count);
    light_req_t req;
    int         sent;
    sent = 0;
    while (sent < count) begin
      req = random_request();
      send_request(req);
      recent_req[req.cmd] = req;
      if (req.cmd <= CMD_BATTERY) sent++;
    end
  endtask

  initial begin : stimulus
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_cmd              = '0;
    in_color            = '0;
    in_flash_mode       = '0;
    in_flash_on_ms      = '0;
    in_flash_off_ms     = '0;
    in_multi_led        = 1'b0;
    in_flashlight_level = '0;
    tx_idle_pct         = 18;
    rx_idle_pct         = 88;
    hold_pending        = 1'b0;
    for (int k = 0; k < 8; k++) recent_req[k] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_fields(CMD_BACKLIGHT, 32'h0000_0000, 2'd0, 16'd0, 16'd0, 1'b0, 8'd0);
    send_fields(CMD_BACKLIGHT, 32'h0000_0000, 2'd0, 16'd0, 16'd0, 1'b0, 8'd0);
    send_fields(CMD_BACKLIGHT, 32'hFFFF_FFFF, 2'd3, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    send_fields(CMD_BACKLIGHT, 32'h0080_0000, 2'd0, 16'd0, 16'd0, 1'b0, 8'd0);
    send_fields(CMD_BACKLIGHT, 32'h40FF_0000, 2'd0, 16'd0, 16'd0, 1'b0, 8'd0);
    send_fields(CMD_BUTTONS, 32'h0000_0000, 2'd0, 16'd0, 16'd0, 1'b0, 8'd0);
    send_fields(CMD_BUTTONS, 32'hFFFF_FFFF, 2'd0, 16'd0, 16'd0, 1'b0, 8'd0);
    send_fields(CMD_BUTTONS, 32'h0101_0101, 2'd0, 16'd0, 16'd0, 1'b0, 8'd0);
    send_fields(CMD_NOTIFY, 32'h00FF_8040, 2'd0, 16'd100, 16'd100, 1'b0, 8'd0);
    send_fields(CMD_NOTIFY, 32'hFF00_FF00, 2'd1, 16'd0, 16'd1, 1'b0, 8'd0);
    send_fields(CMD_NOTIFY, 32'hFF00_FF00, 2'd1, 16'd0, 16'd1, 1'b0, 8'd0);
    send_fields(CMD_BATTERY, 32'h8012_3456, 2'd2, 16'd250, 16'd251, 1'b0, 8'd0);
    send_fields(CMD_ATTENTION, 32'hFF00_00FF, 2'd3, 16'd15000, 16'd15001, 1'b0, 8'd0);
    send_fields(CMD_ATTENTION, 32'h01FF_FFFF, 2'd1, 16'hFFFF, 16'd2, 1'b0, 8'd0);
    send_fields(CMD_ATTENTION, 32'h0000_0000, 2'd0, 16'd0, 16'd0, 1'b0, 8'd0);
    send_fields(CMD_ATTENTION, 32'hFFFF_FFFF, 2'd0, 16'd0, 16'd0, 1'b1, 8'd0);
    send_fields(CMD_ATTENTION, 32'h8080_8080, 2'd0, 16'd0, 16'd0, 1'b1, 8'd100);
    send_fields(CMD_ATTENTION, 32'h0000_0000, 2'd0, 16'd0, 16'd0, 1'b1, 8'd50);
    send_fields(CMD_ATTENTION, 32'h00FF_FFFF, 2'd0, 16'd0, 16'd0, 1'b1, 8'd200);
    send_fields(CMD_ATTENTION, 32'h00FF_FFFF, 2'd0, 16'd0, 16'd0, 1'b1, 8'd0);
    send_fields(CMD_NOTIFY, 32'h0000_0000, 2'd0, 16'd0, 16'd0, 1'b0, 8'd0);
    send_fields(CMD_BATTERY, 32'hFF00_0000, 2'd1, 16'd500, 16'd1000, 1'b0, 8'd0);
    send_fields(3'd5, 32'hFFFF_FFFF, 2'd2, 16'd500, 16'd500, 1'b1, 8'd0);
    send_fields(3'd7, 32'h1234_5678, 2'd1, 16'd700, 16'd900, 1'b0, 8'd7);
    send_fields(CMD_NOTIFY, 32'h0011_2233, 2'd1, 16'd500, 16'd1000, 1'b0, 8'd0);
    send_fields(CMD_NOTIFY, 32'h0011_2233, 2'd2, 16'd2500, 16'd5000, 1'b0, 8'd0);
    send_fields(CMD_NOTIFY, 32'h0011_2233, 2'd1, 16'd8000, 16'd501, 1'b0, 8'd0);

    run_random(85);
    tx_idle_pct = 88;
    rx_idle_pct = 18;
    run_random(85);
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_pending = 1'b1;
    run_random(60);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0 && pending_writes == 0) begin
      $display("indicator_light_arbiter_unit test passed");
    end else begin
      $display("indicator_light_arbiter_unit test failed");
    end
    $finish;
  end

endmodule

### indicator_light_arbiter_unit.f
rtl/ila_pkg.sv
rtl/ila_ctrl.sv
rtl/ila_dp.sv
rtl/indicator_light_arbiter_unit.sv
test/ila_write_monitor.sv
test/tb_top.sv
